// ===== rtl/lrut_pkg.sv =====
// lrut_pkg: shared types and codes of the lru translation buffer
// used by lrut_cell and lru_tlb; depends on nothing
`default_nettype none

package lrut_pkg;

	localparam int KIND_W  = 2;
	localparam int COUNT_W = 32;

	localparam logic [KIND_W-1:0] KIND_LOOKUP = 2'd0;
	localparam logic [KIND_W-1:0] KIND_FILL   = 2'd1;
	localparam logic [KIND_W-1:0] KIND_INVAL  = 2'd2;

	// push: entries move one place towards the tail, head takes the new front
	// pull: entries move one place towards the head, closing a gap
	typedef struct packed {
		logic push;
		logic pull;
	} cell_cmd_t;

endpackage

`default_nettype wire

// ===== rtl/lrut_cell.sv =====
// lrut_cell: one entry of the recency-ordered chain, compare and neighbour shift
// depends on lrut_pkg
`default_nettype none

module lrut_cell #(
	parameter int PAGE_BITS  = 20,
	parameter int FRAME_BITS = 20
) (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire lrut_pkg::cell_cmd_t cmd,
	input  wire  [PAGE_BITS-1:0]    key,
	input  wire                     prev_valid,
	input  wire  [PAGE_BITS-1:0]    prev_page,
	input  wire  [FRAME_BITS-1:0]   prev_frame,
	input  wire                     succ_valid,
	input  wire  [PAGE_BITS-1:0]    succ_page,
	input  wire  [FRAME_BITS-1:0]   succ_frame,
	input  wire                     found_in,
	output logic                    found_out,
	output logic                    match,
	output logic                    valid_q,
	output logic [PAGE_BITS-1:0]    page_q,
	output logic [FRAME_BITS-1:0]   frame_q
);

	logic take_prev;
	logic take_next;

	assign match     = valid_q && (page_q == key);
	assign found_out = found_in || match;

	// on a push only the cells up to and including the matching one move
	assign take_prev = cmd.push && !found_in;
	assign take_next = cmd.pull && (found_in || match);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (take_prev) begin
			valid_q <= prev_valid;
		end else if (take_next) begin
			valid_q <= succ_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take_prev) begin
			page_q  <= prev_page;
			frame_q <= prev_frame;
		end else if (take_next) begin
			page_q  <= succ_page;
			frame_q <= succ_frame;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/lru_tlb.sv =====
// lru_tlb: fully associative translation buffer, chain of cells kept in recency order
// depends on lrut_pkg and lrut_cell
//
//   channel | handshake            | fields
//   in      | in_valid / in_stall  | kind, page_number, frame_number
//   out     | out_valid / out_stall| hit, frame_out, hits_total, misses_total
//
// one item per cycle while the result is not stalled; each result is registered
// the item sits in an input register, then all cells compare and shift at once
// cell 0 is the most recent entry, valid entries always fill the chain from cell 0
// reset clears the valid bits and counters only, no clearing pass
// a stalled result holds the input register, which then stalls the input
`default_nettype none

module lru_tlb #(
	parameter int ENTRIES    = 16,
	parameter int PAGE_BITS  = 20,
	parameter int FRAME_BITS = 20
) (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire                                 in_valid,
	output logic                                in_stall,
	input  wire  [lrut_pkg::KIND_W-1:0]         kind,
	input  wire  [PAGE_BITS-1:0]                page_number,
	input  wire  [FRAME_BITS-1:0]               frame_number,
	output logic                                out_valid,
	input  wire                                 out_stall,
	output logic                                hit,
	output logic [FRAME_BITS-1:0]               frame_out,
	output logic [lrut_pkg::COUNT_W-1:0]        hits_total,
	output logic [lrut_pkg::COUNT_W-1:0]        misses_total
);

	logic                          vld_s1;
	logic [lrut_pkg::KIND_W-1:0]   kind_s1;
	logic [PAGE_BITS-1:0]          page_s1;
	logic [FRAME_BITS-1:0]         frame_s1;

	logic                          out_vld_q;
	logic                          hit_q;
	logic [FRAME_BITS-1:0]         frame_out_q;
	logic [lrut_pkg::COUNT_W-1:0]  hit_cnt_q;
	logic [lrut_pkg::COUNT_W-1:0]  miss_cnt_q;

	logic                          advance;
	logic                          accept;
	logic                          any_match;
	logic [FRAME_BITS-1:0]         match_frame;
	logic [FRAME_BITS-1:0]         head_frame;
	lrut_pkg::cell_cmd_t           cmd;

	logic                          cv [ENTRIES];
	logic [PAGE_BITS-1:0]          cp [ENTRIES];
	logic [FRAME_BITS-1:0]         cf [ENTRIES];
	logic [ENTRIES-1:0]            match_vec;
	logic [ENTRIES-1:0]            valid_vec;
	logic [ENTRIES:0]              found;

	assign advance  = vld_s1 && (!out_vld_q || !out_stall);
	assign in_stall = vld_s1 && !advance;
	assign accept   = in_valid && !in_stall;

	assign found[0]  = 1'b0;
	assign any_match = |match_vec;

	always_comb begin
		match_frame = '0;
		for (int i = 0; i < ENTRIES; i++) begin
			if (match_vec[i]) begin
				match_frame = match_frame | cf[i];
			end
		end
	end

	assign head_frame = (kind_s1 == lrut_pkg::KIND_FILL) ? frame_s1 : match_frame;

	always_comb begin
		cmd.push = advance && (((kind_s1 == lrut_pkg::KIND_LOOKUP) && any_match) ||
			(kind_s1 == lrut_pkg::KIND_FILL));
		cmd.pull = advance && (kind_s1 == lrut_pkg::KIND_INVAL) && any_match;
	end

	genvar g;
	generate
		for (g = 0; g < ENTRIES; g++) begin : g_cell
			logic                  pv;
			logic [PAGE_BITS-1:0]  pp;
			logic [FRAME_BITS-1:0] pf;
			logic                  nv;
			logic [PAGE_BITS-1:0]  np;
			logic [FRAME_BITS-1:0] nf;

			if (g == 0) begin : g_head
				assign pv = 1'b1;
				assign pp = page_s1;
				assign pf = head_frame;
			end else begin : g_mid
				assign pv = cv[g-1];
				assign pp = cp[g-1];
				assign pf = cf[g-1];
			end

			if (g == ENTRIES-1) begin : g_tail
				assign nv = 1'b0;
				assign np = '0;
				assign nf = '0;
			end else begin : g_body
				assign nv = cv[g+1];
				assign np = cp[g+1];
				assign nf = cf[g+1];
			end

			lrut_cell #(
				.PAGE_BITS  (PAGE_BITS),
				.FRAME_BITS (FRAME_BITS)
			) u_cell (
				.clk        (clk),
				.arst_n     (arst_n),
				.cmd        (cmd),
				.key        (page_s1),
				.prev_valid (pv),
				.prev_page  (pp),
				.prev_frame (pf),
				.succ_valid (nv),
				.succ_page  (np),
				.succ_frame (nf),
				.found_in   (found[g]),
				.found_out  (found[g+1]),
				.match      (match_vec[g]),
				.valid_q    (cv[g]),
				.page_q     (cp[g]),
				.frame_q    (cf[g])
			);

			assign valid_vec[g] = cv[g];
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (accept) begin
			vld_s1 <= 1'b1;
		end else if (advance) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_s1  <= kind;
			page_s1  <= page_number;
			frame_s1 <= frame_number;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			hit_cnt_q  <= '0;
			miss_cnt_q <= '0;
		end else if (advance) begin
			out_vld_q <= 1'b1;
			if (kind_s1 == lrut_pkg::KIND_LOOKUP) begin
				if (any_match) begin
					hit_cnt_q <= hit_cnt_q + 1'b1;
				end else begin
					miss_cnt_q <= miss_cnt_q + 1'b1;
				end
			end
		end else if (!out_stall) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			hit_q <= any_match && (kind_s1 == lrut_pkg::KIND_LOOKUP ||
				kind_s1 == lrut_pkg::KIND_FILL || kind_s1 == lrut_pkg::KIND_INVAL);
			frame_out_q <= (any_match && kind_s1 == lrut_pkg::KIND_LOOKUP) ?
				match_frame : '0;
		end
	end

	assign out_valid    = out_vld_q;
	assign hit          = hit_q;
	assign frame_out    = frame_out_q;
	assign hits_total   = hit_cnt_q;
	assign misses_total = miss_cnt_q;

	a_one_match: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 |-> $onehot0(match_vec))
		else $error("page held in more than one entry");

	a_packed_front: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_vec & (valid_vec + 1'b1)) == '0)
		else $error("valid entries not packed from the head");

	a_lookup_counts: assert property (@(posedge clk) disable iff (!arst_n)
		advance && kind_s1 == lrut_pkg::KIND_LOOKUP |=>
		lrut_pkg::COUNT_W'(hit_cnt_q + miss_cnt_q) ==
		lrut_pkg::COUNT_W'($past(hit_cnt_q) + $past(miss_cnt_q) + 1'b1))
		else $error("lookup did not count exactly once");

	a_other_no_count: assert property (@(posedge clk) disable iff (!arst_n)
		!(advance && kind_s1 == lrut_pkg::KIND_LOOKUP) |=>
		$stable(hit_cnt_q) && $stable(miss_cnt_q))
		else $error("counter moved without a lookup");

	a_frame_on_hit: assert property (@(posedge clk) disable iff (!arst_n)
		out_vld_q && !hit_q |-> frame_out_q == '0)
		else $error("frame shown without a hit");

endmodule

`default_nettype wire
